// ===== src/crcx_pkg.sv =====
// ----------------------------------------------------------------------------
// crcx_pkg
// Shared types, constants and CRC-16/MCRF4XX byte-update functions for the
// eight-byte streaming CRC block.
// ----------------------------------------------------------------------------
package crcx_pkg;

  localparam int unsigned LANE_BYTES_DEF = 8;
  localparam int unsigned DATA_W         = 64;
  localparam int unsigned CNT_W          = 4;
  localparam int unsigned CRC_W          = 16;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned ADDR_W         = 3;
  localparam int unsigned PDATA_W        = 32;
  localparam int unsigned ZERO_STEPS_MAX = 8;

  localparam logic [CRC_W-1:0] SEED_RST = 16'hFFFF;

  // Register word index, taken from paddr above the byte offset
  typedef enum logic [0:0] {
    REG_CRC_SEED = 1'b0,
    REG_NONE     = 1'b1
  } reg_idx_t;

  typedef logic [CRC_W-1:0] crc_t;

  // Control carried alongside the lane terms into the merge stage
  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic             start;
    logic             last;
  } s1_ctrl_t;

  // Reflected X.25 update of one byte
  function automatic crc_t fold_byte(crc_t c, logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] t;
    crc_t              r;
    t = b ^ c[7:0];
    t = t ^ {t[3:0], 4'b0000};
    r = {8'h00, c[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
    return r;
  endfunction

  // Contribution of one byte folded into a zero CRC, then pushed through
  // a fixed number of zero bytes (constant per lane, so this flattens to XORs)
  function automatic crc_t byte_term(logic [BYTE_W-1:0] b, int unsigned steps);
    crc_t c;
    c = fold_byte('0, b);
    for (int unsigned k = 0; k < ZERO_STEPS_MAX - 1; k++) begin
      if (k < steps) begin
        c = fold_byte(c, '0);
      end
    end
    return c;
  endfunction

  // Push a CRC through n zero bytes, n at most eight
  function automatic crc_t advance(crc_t c, logic [CNT_W-1:0] n);
    crc_t r;
    r = c;
    for (int unsigned k = 0; k < ZERO_STEPS_MAX; k++) begin
      if (CNT_W'(k) < n) begin
        r = fold_byte(r, '0);
      end
    end
    return r;
  endfunction

endpackage

// ===== src/crcx_lane.sv =====
// ----------------------------------------------------------------------------
// crcx_lane
// One byte lane: picks the message byte that lands on this lane once the
// item's bytes are right-aligned, and forms its CRC contribution.
// ----------------------------------------------------------------------------
module crcx_lane #(
  parameter int unsigned LANE_BYTES = crcx_pkg::LANE_BYTES_DEF,
  parameter int unsigned POS        = 0
) (
  input  logic [LANE_BYTES-1:0][crcx_pkg::BYTE_W-1:0] data_bytes,
  input  logic [crcx_pkg::CNT_W-1:0]                  n,
  output crcx_pkg::crc_t                              term
);

  localparam int unsigned IDX_W = (LANE_BYTES > 1) ? $clog2(LANE_BYTES) : 1;

  logic             used;
  logic [IDX_W-1:0] sel;

  // Lane POS carries byte (POS + n - LANE_BYTES); leading lanes stay empty
  assign used = (int'(n) + int'(POS)) >= int'(LANE_BYTES);
  assign sel  = IDX_W'(int'(n) + int'(POS) - int'(LANE_BYTES));

  // Fold the byte and age it by the bytes that follow it
  always_comb begin
    if (used) begin
      term = crcx_pkg::byte_term(data_bytes[sel], LANE_BYTES - 1 - POS);
    end else begin
      term = '0;
    end
  end

endmodule

// ===== src/crcx_merge.sv =====
// ----------------------------------------------------------------------------
// crcx_merge
// Combines the lane terms and the aged running CRC into the new running
// value, and holds that value.
// ----------------------------------------------------------------------------
module crcx_merge #(
  parameter int unsigned LANE_BYTES = crcx_pkg::LANE_BYTES_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        load,
  input  logic [LANE_BYTES-1:0][crcx_pkg::CRC_W-1:0]  terms,
  input  crcx_pkg::s1_ctrl_t                          ctrl,
  input  crcx_pkg::crc_t                              seed,
  output crcx_pkg::crc_t                              crc
);

  crcx_pkg::crc_t data_sum;
  crcx_pkg::crc_t base;
  crcx_pkg::crc_t running_crc_r;
  crcx_pkg::crc_t running_crc_nxt;

  // XOR the lane terms together
  always_comb begin
    data_sum = '0;
    for (int unsigned k = 0; k < LANE_BYTES; k++) begin
      data_sum = data_sum ^ terms[k];
    end
  end

  // Age the starting value by the byte count and add the data part
  assign base            = ctrl.start ? seed : running_crc_r;
  assign running_crc_nxt = crcx_pkg::advance(base, ctrl.n) ^ data_sum;

  // Hold the running CRC
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_crc_r <= crcx_pkg::SEED_RST;
    end else if (load) begin
      running_crc_r <= running_crc_nxt;
    end
  end

  assign crc = running_crc_r;

endmodule

// ===== src/crc16_x25_eight_byte_stream.sv =====
// ----------------------------------------------------------------------------
// crc16_x25_eight_byte_stream
// Running CRC-16/MCRF4XX over a stream of items of up to eight bytes each.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+----------------------------
//   in_      | sink      | in_valid / in_ready    | data_bytes, byte_count,
//            |           |                        | start_msg, last_chunk
//   out_     | source    | out_valid / out_ready  | crc_value, final_result
//   APB      | slave     | psel/penable/pready    | crc_seed at byte address 0
//
// One item per cycle sustained unless the output stalls; items pass the
// stage-1 and running-CRC registers. The cycle is set by the running-CRC loop
// in the merge stage: aging the running value through up to eight zero bytes
// and adding the lane terms. Reset (rst_n low, synchronous) empties the
// pipeline and loads the seed and running CRC with 0xFFFF. A stalled output
// holds the stage before it; in_ready stays high while either stage has room.
// ----------------------------------------------------------------------------
module crc16_x25_eight_byte_stream #(
  parameter int unsigned LANE_BYTES = crcx_pkg::LANE_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input items
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [crcx_pkg::DATA_W-1:0]    in_data_bytes,
  input  logic [crcx_pkg::CNT_W-1:0]     in_byte_count,
  input  logic                           in_start_msg,
  input  logic                           in_last_chunk,
  // result items
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [crcx_pkg::CRC_W-1:0]     out_crc_value,
  output logic                           out_final_result,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [crcx_pkg::ADDR_W-1:0]    paddr,
  input  logic [crcx_pkg::PDATA_W-1:0]   pwdata,
  output logic [crcx_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  logic [LANE_BYTES-1:0][crcx_pkg::CRC_W-1:0] lane_term;
  logic [LANE_BYTES-1:0][crcx_pkg::CRC_W-1:0] s1_term_r;
  logic [crcx_pkg::CNT_W-1:0]                 n_sat;
  crcx_pkg::s1_ctrl_t                         s1_ctrl_r;
  logic                                       s1_valid_r;
  logic                                       out_valid_r;
  logic                                       out_last_r;
  crcx_pkg::crc_t                             seed_r;
  crcx_pkg::reg_idx_t                         reg_idx;
  logic                                       s1_load;
  logic                                       s2_load;
  logic                                       cfg_wr;

  // Clamp the count to the lane width
  assign n_sat = (int'(in_byte_count) > int'(LANE_BYTES)) ?
                 crcx_pkg::CNT_W'(LANE_BYTES) : in_byte_count;

  // Byte lanes
  for (genvar g = 0; g < LANE_BYTES; g++) begin : g_lane
    crcx_lane #(
      .LANE_BYTES (LANE_BYTES),
      .POS        (g)
    ) u_lane (
      .data_bytes (in_data_bytes[LANE_BYTES*crcx_pkg::BYTE_W-1:0]),
      .n          (n_sat),
      .term       (lane_term[g])
    );
  end

  // Pipeline flow: stage 2 moves when the output slot is free or draining
  assign s2_load  = s1_valid_r && (!out_valid_r || out_ready);
  assign s1_load  = in_valid && in_ready;
  assign in_ready = !s1_valid_r || s2_load;

  // Stage 1 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_term_r       <= lane_term;
      s1_ctrl_r.n     <= n_sat;
      s1_ctrl_r.start <= in_start_msg;
      s1_ctrl_r.last  <= in_last_chunk;
    end
  end

  // Merge lanes into the running CRC
  crcx_merge #(
    .LANE_BYTES (LANE_BYTES)
  ) u_merge (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (s2_load),
    .terms (s1_term_r),
    .ctrl  (s1_ctrl_r),
    .seed  (seed_r),
    .crc   (out_crc_value)
  );

  // Output slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      out_last_r <= s1_ctrl_r.last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_final_result = out_last_r;

  // Configuration register
  assign reg_idx = crcx_pkg::reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= crcx_pkg::SEED_RST;
    end else if (cfg_wr && (reg_idx == crcx_pkg::REG_CRC_SEED)) begin
      seed_r <= pwdata[crcx_pkg::CRC_W-1:0];
    end
  end

  always_comb begin
    case (reg_idx)
      crcx_pkg::REG_CRC_SEED: prdata = {{(crcx_pkg::PDATA_W - crcx_pkg::CRC_W){1'b0}}, seed_r};
      default:                prdata = '0;
    endcase
  end

endmodule

// ===== src/crcx_checker.sv =====
// ----------------------------------------------------------------------------
// crcx_checker
// Port-level checks for the streaming CRC block, bound to the top level.
// ----------------------------------------------------------------------------
module crcx_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [crcx_pkg::CRC_W-1:0]   out_crc_value,
  input logic                         out_final_result,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [crcx_pkg::ADDR_W-1:0]  paddr,
  input logic [crcx_pkg::PDATA_W-1:0] pwdata,
  input logic [crcx_pkg::PDATA_W-1:0] prdata,
  input logic                         pready
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_crc_value) &&
                                $stable(out_final_result))
    else $error("result changed while stalled");

  // Input back-pressure only comes from a stalled output
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("in_ready low without output stall");

  // An offered item stays offered until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid)
    else $error("input item withdrawn before acceptance");

  // Nothing is offered straight after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result offered after reset");

  // A written seed reads back
  a_seed_readback: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && pready && !paddr[2] |=>
      (!psel || pwrite || paddr[2] ||
       prdata[crcx_pkg::CRC_W-1:0] == $past(pwdata[crcx_pkg::CRC_W-1:0])))
    else $error("seed read-back mismatch");

endmodule

bind crc16_x25_eight_byte_stream crcx_checker u_crcx_checker (.*);

// ===== tb/crc16_x25_eight_byte_stream_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crc16_x25_eight_byte_stream_tb
// Self-checking bench for the streaming CRC-16/MCRF4XX block. A directed
// table covers the seed reload, empty and oversized byte counts, writes to an
// unmapped register and the standard check string. Randomised messages follow
// under several seeds. A bit-serial reflected CRC in the bench predicts each
// result not in the table. Both channels idle at random, bar the last phase.
// ----------------------------------------------------------------------------
module crc16_x25_eight_byte_stream_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 175;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t                    kind;
    crcx_pkg::reg_idx_t           reg_sel;
    logic [crcx_pkg::PDATA_W-1:0] wvalue;
    logic [crcx_pkg::DATA_W-1:0]  data;
    logic [crcx_pkg::CNT_W-1:0]   count;
    logic                         start;
    logic                         last;
    logic                         has_exp;
    logic [crcx_pkg::CRC_W-1:0]   exp_crc;
  } row_t;

  typedef struct packed {
    logic [crcx_pkg::CRC_W-1:0] crc;
    logic                       final_flag;
  } crc_result_t;

  logic                          clk              = 1'b0;
  logic                          rst_n            = 1'b0;
  logic                          in_valid         = 1'b0;
  logic                          in_ready;
  logic [crcx_pkg::DATA_W-1:0]   in_data_bytes    = '0;
  logic [crcx_pkg::CNT_W-1:0]    in_byte_count    = '0;
  logic                          in_start_msg     = 1'b0;
  logic                          in_last_chunk    = 1'b0;
  logic                          out_valid;
  logic                          out_ready        = 1'b0;
  logic [crcx_pkg::CRC_W-1:0]    out_crc_value;
  logic                          out_final_result;
  logic                          psel             = 1'b0;
  logic                          penable          = 1'b0;
  logic                          pwrite           = 1'b0;
  logic [crcx_pkg::ADDR_W-1:0]   paddr            = '0;
  logic [crcx_pkg::PDATA_W-1:0]  pwdata           = '0;
  logic [crcx_pkg::PDATA_W-1:0]  prdata;
  logic                          pready;

  // Predictor state: seed register and running CRC as the block should hold them
  logic [crcx_pkg::CRC_W-1:0]    seed_shadow = crcx_pkg::SEED_RST;
  logic [crcx_pkg::CRC_W-1:0]    crc_run     = crcx_pkg::SEED_RST;

  crc_result_t         crc_expected_q [$];
  row_t                directed_rows  [$];
  int                  errors       = 0;
  int                  quiet_cycles = 0;
  int                  stall_left   = 0;
  logic                idle_on      = 1'b1;

  crc16_x25_eight_byte_stream i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_bytes    (in_data_bytes),
    .in_byte_count    (in_byte_count),
    .in_start_msg     (in_start_msg),
    .in_last_chunk    (in_last_chunk),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_crc_value    (out_crc_value),
    .out_final_result (out_final_result),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Reflected polynomial 0x8408, one bit at a time, LSB first
  function automatic logic [crcx_pkg::CRC_W-1:0] crc_fold_byte(
      logic [crcx_pkg::CRC_W-1:0] c, logic [crcx_pkg::BYTE_W-1:0] b);
    logic [crcx_pkg::CRC_W-1:0] r;
    r = c ^ {8'h00, b};
    for (int i = 0; i < crcx_pkg::BYTE_W; i++) begin
      r = r[0] ? ((r >> 1) ^ 16'h8408) : (r >> 1);
    end
    return r;
  endfunction

  // Fold one item into the running CRC; counts past the lane width saturate
  function automatic logic [crcx_pkg::CRC_W-1:0] fold_item(
      logic [crcx_pkg::DATA_W-1:0] d, logic [crcx_pkg::CNT_W-1:0] n, logic s);
    logic [crcx_pkg::CRC_W-1:0] c;
    int                         nb;
    c  = s ? seed_shadow : crc_run;
    nb = (int'(n) > int'(crcx_pkg::LANE_BYTES_DEF)) ?
         int'(crcx_pkg::LANE_BYTES_DEF) : int'(n);
    for (int k = 0; k < nb; k++) begin
      c = crc_fold_byte(c, d[8*k +: 8]);
    end
    crc_run = c;
    return c;
  endfunction

  function automatic row_t item_row(logic [crcx_pkg::DATA_W-1:0] d,
                                    logic [crcx_pkg::CNT_W-1:0] n,
                                    logic s, logic l, logic has_exp,
                                    logic [crcx_pkg::CRC_W-1:0] exp_crc);
    row_t r;
    r         = '0;
    r.kind    = ROW_ITEM;
    r.data    = d;
    r.count   = n;
    r.start   = s;
    r.last    = l;
    r.has_exp = has_exp;
    r.exp_crc = exp_crc;
    return r;
  endfunction

  function automatic row_t cfg_row(crcx_pkg::reg_idx_t idx,
                                   logic [crcx_pkg::PDATA_W-1:0] v);
    row_t r;
    r         = '0;
    r.kind    = ROW_CFG;
    r.reg_sel = idx;
    r.wvalue  = v;
    return r;
  endfunction

  // Offer one item after an optional gap, hold until taken, then log its CRC
  task automatic send_item(logic [crcx_pkg::DATA_W-1:0] d,
                           logic [crcx_pkg::CNT_W-1:0] n, logic s,
                           logic l, logic has_exp,
                           logic [crcx_pkg::CRC_W-1:0] exp_crc);
    int          gap;
    crc_result_t r;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_bytes <= d;
    in_byte_count <= n;
    in_start_msg  <= s;
    in_last_chunk <= l;
    do @(posedge clk); while (!in_ready);
    r.crc        = fold_item(d, n, s);
    r.final_flag = l;
    if (has_exp) begin
      r.crc = exp_crc;
    end
    crc_expected_q.push_back(r);
  endtask

  // Drop valid and hold until every outstanding result has been taken
  task automatic drain;
    in_valid <= 1'b0;
    while (crc_expected_q.size() != 0) @(posedge clk);
  endtask

  // Register write, then read the seed back
  task automatic cfg_write(crcx_pkg::reg_idx_t idx, logic [crcx_pkg::PDATA_W-1:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == crcx_pkg::REG_CRC_SEED) begin
      seed_shadow = v[crcx_pkg::CRC_W-1:0];
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    psel    <= 1'b1;
    paddr   <= {crcx_pkg::REG_CRC_SEED, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {16'h0000, seed_shadow}) begin
      $error("crc_seed readback: expected %08h, got %08h",
             {16'h0000, seed_shadow}, prdata);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly well-formed messages with random content, some noise and breakage
  task automatic run_messages(int n_items);
    int                         sent;
    int                         chunks;
    int                         r;
    logic                       s;
    logic                       l;
    logic [crcx_pkg::CNT_W-1:0] n;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item({$urandom, $urandom}, crcx_pkg::CNT_W'($urandom), 1'($urandom),
                  1'($urandom), 1'b0, '0);
        sent++;
      end else begin
        chunks = $urandom_range(1, 6);
        for (int k = 0; k < chunks; k++) begin
          s = (k == 0);
          l = (k == chunks - 1);
          if ($urandom_range(0, 15) == 0) s = ~s;
          if ($urandom_range(0, 15) == 0) l = ~l;
          r = $urandom_range(0, 19);
          if (r == 0)      n = '0;
          else if (r == 1) n = crcx_pkg::CNT_W'($urandom_range(9, 15));
          else             n = crcx_pkg::CNT_W'($urandom_range(1, 8));
          send_item({$urandom, $urandom}, n, s, l, 1'b0, '0);
          sent++;
        end
      end
    end
  endtask

  // Result side: random stall bursts, compare each result with the oldest entry
  always @(posedge clk) begin
    crc_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (crc_expected_q.size() == 0) begin
        $error("unexpected result: crc_value %04h, final_result %0b",
               out_crc_value, out_final_result);
        errors++;
      end else begin
        e = crc_expected_q.pop_front();
        if (out_crc_value !== e.crc) begin
          $error("crc_value: expected %04h, got %04h", e.crc, out_crc_value);
          errors++;
        end
        if (out_final_result !== e.final_flag) begin
          $error("final_result: expected %0b, got %0b", e.final_flag,
                 out_final_result);
          errors++;
        end
      end
    end
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rst_n && idle_on && $urandom_range(0, 7) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 11);
    end else begin
      out_ready  <= rst_n;
    end
  end

  // Watchdog: end the run when nothing moves on any port for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    // After reset: seed and running CRC both at all ones
    directed_rows.push_back(item_row(64'h0, 4'd0, 1'b0, 1'b0, 1'b1, 16'hFFFF));
    directed_rows.push_back(item_row('1, 4'd0, 1'b1, 1'b1, 1'b1, 16'hFFFF));
    // Check string "123456789" across two items
    directed_rows.push_back(item_row(64'h3837363534333231, 4'd8, 1'b1, 1'b0,
                                     1'b0, '0));
    directed_rows.push_back(item_row(64'h39, 4'd1, 1'b0, 1'b1, 1'b1, 16'h6F91));
    // Unmapped register: seed stays at all ones
    directed_rows.push_back(cfg_row(crcx_pkg::REG_NONE, 32'h0000_1234));
    directed_rows.push_back(item_row(64'h0, 4'd0, 1'b1, 1'b0, 1'b1, 16'hFFFF));
    // Zero seed: empty item and zero bytes both give zero
    directed_rows.push_back(cfg_row(crcx_pkg::REG_CRC_SEED, 32'h0000_0000));
    directed_rows.push_back(item_row('1, 4'd0, 1'b1, 1'b1, 1'b1, 16'h0000));
    directed_rows.push_back(item_row(64'h0, 4'd8, 1'b1, 1'b0, 1'b1, 16'h0000));
    directed_rows.push_back(item_row('1, 4'd8, 1'b0, 1'b0, 1'b0, '0));
    // Oversized counts saturate at the lane width
    directed_rows.push_back(item_row(64'h0123456789ABCDEF, 4'd9, 1'b0, 1'b0,
                                     1'b0, '0));
    directed_rows.push_back(item_row(64'hFEDCBA9876543210, 4'd15, 1'b1, 1'b1,
                                     1'b0, '0));
    // Upper write bits ignored: seed back to all ones
    directed_rows.push_back(cfg_row(crcx_pkg::REG_CRC_SEED, 32'hABCD_FFFF));
    directed_rows.push_back(item_row(64'h8000000000000001, 4'd1, 1'b1, 1'b0,
                                     1'b0, '0));
    directed_rows.push_back(item_row(64'h5A5A5A5A5A5A5A5A, 4'd4, 1'b0, 1'b0,
                                     1'b0, '0));
    // Restart with no closing chunk before it
    directed_rows.push_back(item_row(64'hA5A5A5A5A5A5A5A5, 4'd7, 1'b1, 1'b0,
                                     1'b0, '0));
    directed_rows.push_back(item_row(64'h7FFFFFFFFFFFFFFF, 4'd8, 1'b0, 1'b1,
                                     1'b0, '0));
    directed_rows.push_back(cfg_row(crcx_pkg::REG_CRC_SEED, 32'h0000_1D0F));
    directed_rows.push_back(item_row(64'h0, 4'd0, 1'b0, 1'b0, 1'b0, '0));
    directed_rows.push_back(item_row(64'hDEADBEEFCAFEF00D, 4'd3, 1'b1, 1'b1,
                                     1'b0, '0));
    directed_rows.push_back(item_row('1, 4'd8, 1'b1, 1'b1, 1'b0, '0));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        drain();
        cfg_write(directed_rows[i].reg_sel, directed_rows[i].wvalue);
      end else begin
        send_item(directed_rows[i].data, directed_rows[i].count,
                  directed_rows[i].start, directed_rows[i].last,
                  directed_rows[i].has_exp, directed_rows[i].exp_crc);
      end
    end

    // Random phases under different seeds; the last one runs without idling
    for (int p = 0; p < 4; p++) begin
      drain();
      case (p)
        0: cfg_write(crcx_pkg::REG_CRC_SEED, $urandom);
        1: begin
          cfg_write(crcx_pkg::REG_CRC_SEED, 32'h0000_0000);
          cfg_write(crcx_pkg::REG_NONE, $urandom);
        end
        2: cfg_write(crcx_pkg::REG_CRC_SEED, 32'h0000_FFFF);
        default: begin
          cfg_write(crcx_pkg::REG_CRC_SEED, $urandom);
          idle_on = 1'b0;
        end
      endcase
      run_messages(PHASE_ITEMS);
    end

    drain();
    repeat (8) @(posedge clk);
    if (crc_expected_q.size() != 0) begin
      $error("%0d results never arrived", crc_expected_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
